FILE: rtl/spo_pkg.sv
// ----------------------------------------------------------------------------
// spo_pkg: shared types and constants for the sequence partition offset block
// Field widths, clamp limits, register map, mode codes and inter-module structs.
// ----------------------------------------------------------------------------
package spo_pkg;

	// Field widths
	localparam int STEP_W  = 16;
	localparam int GRP_W   = 4;
	localparam int RANK_W  = 8;
	localparam int CNT_W   = RANK_W + 1;
	localparam int SPLIT_W = 5;
	localparam int SEQ_W   = 21;
	localparam int MODE_W  = 2;
	localparam int OFF_W   = 20;

	// Clamp limits
	localparam int MAX_RANKS    = 256;
	localparam int MAX_SEQUENCE = 1048576;
	localparam int MAX_SPLITS   = 16;

	// Chunk index and divisor width: holds split count times rank count
	localparam int IDX_W  = 13;
	localparam int PROD_W = IDX_W + SEQ_W;

	// Configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_RANK_COUNT  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_OWN_RANK    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_SEQ_LENGTH  = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_SPLIT_COUNT = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_PART_MODE   = REG_IDX_W'(4);

	// Register reset values
	localparam logic [CNT_W-1:0]   RST_RANK_COUNT  = CNT_W'(1);
	localparam logic [RANK_W-1:0]  RST_OWN_RANK    = '0;
	localparam logic [SEQ_W-1:0]   RST_SEQ_LENGTH  = SEQ_W'(1);
	localparam logic [SPLIT_W-1:0] RST_SPLIT_COUNT = SPLIT_W'(2);
	localparam logic [MODE_W-1:0]  RST_PART_MODE   = '0;

	// Partition modes; the unused code behaves as contiguous
	localparam logic [MODE_W-1:0] MODE_CONTIG  = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_ZIGZAG  = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_STRIPED = MODE_W'(2);

	// Configuration sequencer states
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_PREP,
		CS_DIV_LEN,
		CS_DIV_CHUNK,
		CS_DIV_OWN
	} cfg_state_t;

	// Derived configuration handed to the datapath
	typedef struct packed {
		logic [CNT_W-1:0]   n;
		logic [SPLIT_W-1:0] s;
		logic [RANK_W-1:0]  r;
		logic [MODE_W-1:0]  mode;
		logic [SEQ_W-1:0]   len_c;
		logic [SEQ_W-1:0]   len_z;
		logic               busy;
	} cfg_t;

	// Result of the step reduction pipeline
	typedef struct packed {
		logic [RANK_W-1:0] step_mod;
		logic [GRP_W-1:0]  grp;
	} mod_out_t;

endpackage

FILE: rtl/spo_cfg.sv
// ----------------------------------------------------------------------------
// spo_cfg: configuration registers and derived-value sequencer
// Holds the APB registers, clamps them, and runs a shared restoring divider to
// get seq/N, seq/(S*N) and own mod N after reset and after every write.
// ----------------------------------------------------------------------------
module spo_cfg import spo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	localparam int DIV_CNT_W = $clog2(SEQ_W);

	logic [CNT_W-1:0]     rank_count_q;
	logic [RANK_W-1:0]    own_rank_q;
	logic [SEQ_W-1:0]     seq_length_q;
	logic [SPLIT_W-1:0]   split_count_q;
	logic [MODE_W-1:0]    part_mode_q;

	logic [CNT_W-1:0]     n_clamp;
	logic [SPLIT_W-1:0]   s_clamp;
	logic [SEQ_W-1:0]     seq_clamp;
	logic [CNT_W-1:0]     n_q;
	logic [SPLIT_W-1:0]   s_q;
	logic [SEQ_W-1:0]     seq_q;
	logic [SEQ_W-1:0]     len_c_q;
	logic [SEQ_W-1:0]     len_z_q;
	logic [RANK_W-1:0]    r_q;
	logic [CNT_W+SPLIT_W-1:0] sn_full;
	logic [IDX_W-1:0]     sn;

	cfg_state_t           state_q;
	cfg_state_t           state_d;
	logic                 wr;
	logic [REG_IDX_W-1:0] widx;

	logic                 load;
	logic                 run;
	logic                 busy;
	logic [SEQ_W-1:0]     ld_dvd;
	logic [IDX_W-1:0]     ld_dsr;
	logic [SEQ_W-1:0]     dvd_q;
	logic [IDX_W-1:0]     dsr_q;
	logic [IDX_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [IDX_W:0]       shifted;
	logic                 ge;
	logic [IDX_W:0]       rem_diff;
	logic [IDX_W-1:0]     rem_n;
	logic [SEQ_W-1:0]     dvd_n;
	logic                 div_last;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign widx   = paddr[APB_ADDR_W-1:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_count_q  <= RST_RANK_COUNT;
			own_rank_q    <= RST_OWN_RANK;
			seq_length_q  <= RST_SEQ_LENGTH;
			split_count_q <= RST_SPLIT_COUNT;
			part_mode_q   <= RST_PART_MODE;
		end else if (wr) begin
			unique case (widx)
				REG_RANK_COUNT:  rank_count_q  <= pwdata[CNT_W-1:0];
				REG_OWN_RANK:    own_rank_q    <= pwdata[RANK_W-1:0];
				REG_SEQ_LENGTH:  seq_length_q  <= pwdata[SEQ_W-1:0];
				REG_SPLIT_COUNT: split_count_q <= pwdata[SPLIT_W-1:0];
				REG_PART_MODE:   part_mode_q   <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (widx)
			REG_RANK_COUNT:  prdata = APB_DATA_W'(rank_count_q);
			REG_OWN_RANK:    prdata = APB_DATA_W'(own_rank_q);
			REG_SEQ_LENGTH:  prdata = APB_DATA_W'(seq_length_q);
			REG_SPLIT_COUNT: prdata = APB_DATA_W'(split_count_q);
			REG_PART_MODE:   prdata = APB_DATA_W'(part_mode_q);
			default:         prdata = '0;
		endcase
	end

	// Clamp counts to their legal ranges
	always_comb begin
		if (rank_count_q == '0) begin
			n_clamp = CNT_W'(1);
		end else if (rank_count_q > CNT_W'(MAX_RANKS)) begin
			n_clamp = CNT_W'(MAX_RANKS);
		end else begin
			n_clamp = rank_count_q;
		end
		if (split_count_q == '0) begin
			s_clamp = SPLIT_W'(1);
		end else if (split_count_q > SPLIT_W'(MAX_SPLITS)) begin
			s_clamp = SPLIT_W'(MAX_SPLITS);
		end else begin
			s_clamp = split_count_q;
		end
		if (seq_length_q > SEQ_W'(MAX_SEQUENCE)) begin
			seq_clamp = SEQ_W'(MAX_SEQUENCE);
		end else begin
			seq_clamp = seq_length_q;
		end
	end

	assign sn_full = (CNT_W+SPLIT_W)'(s_q) * (CNT_W+SPLIT_W)'(n_q);
	assign sn      = sn_full[IDX_W-1:0];

	// One restoring divide step
	always_comb begin
		shifted  = {rem_q, dvd_q[SEQ_W-1]};
		ge       = shifted >= {1'b0, dsr_q};
		rem_diff = shifted - {1'b0, dsr_q};
		rem_n    = ge ? rem_diff[IDX_W-1:0] : shifted[IDX_W-1:0];
		dvd_n    = {dvd_q[SEQ_W-2:0], ge};
	end

	assign div_last = cnt_q == DIV_CNT_W'(SEQ_W - 1);

	// Sequencer next state; any write restarts the sequence
	always_comb begin
		state_d = state_q;
		if (wr) begin
			state_d = CS_PREP;
		end else begin
			unique case (state_q)
				CS_IDLE:      state_d = CS_IDLE;
				CS_PREP:      state_d = CS_DIV_LEN;
				CS_DIV_LEN:   if (div_last) state_d = CS_DIV_CHUNK;
				CS_DIV_CHUNK: if (div_last) state_d = CS_DIV_OWN;
				CS_DIV_OWN:   if (div_last) state_d = CS_IDLE;
				default:      state_d = CS_IDLE;
			endcase
		end
	end

	// Sequencer outputs: divider load and run
	always_comb begin
		load   = 1'b0;
		run    = 1'b0;
		ld_dvd = seq_clamp;
		ld_dsr = IDX_W'(n_clamp);
		busy   = wr || (state_q != CS_IDLE);
		unique case (state_q)
			CS_IDLE: ;
			CS_PREP: load = 1'b1;
			CS_DIV_LEN: begin
				run = 1'b1;
				if (div_last) begin
					load   = 1'b1;
					ld_dvd = seq_q;
					ld_dsr = sn;
				end
			end
			CS_DIV_CHUNK: begin
				run = 1'b1;
				if (div_last) begin
					load   = 1'b1;
					ld_dvd = SEQ_W'(own_rank_q);
					ld_dsr = IDX_W'(n_q);
				end
			end
			CS_DIV_OWN: run = 1'b1;
			default: ;
		endcase
	end

	// Sequencer state and step counter; reset starts a fresh sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_PREP;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q <= '0;
			end else if (run) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// Divider datapath and captured results
	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= ld_dvd;
			dsr_q <= ld_dsr;
			rem_q <= '0;
		end else if (run) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
		if (state_q == CS_PREP) begin
			n_q   <= n_clamp;
			s_q   <= s_clamp;
			seq_q <= seq_clamp;
		end
		if (state_q == CS_DIV_LEN && div_last) begin
			len_c_q <= dvd_n;
		end
		if (state_q == CS_DIV_CHUNK && div_last) begin
			len_z_q <= dvd_n;
		end
		if (state_q == CS_DIV_OWN && div_last) begin
			r_q <= rem_n[RANK_W-1:0];
		end
	end

	always_comb begin
		cfg.n     = n_q;
		cfg.s     = s_q;
		cfg.r     = r_q;
		cfg.mode  = part_mode_q;
		cfg.len_c = len_c_q;
		cfg.len_z = len_z_q;
		cfg.busy  = busy;
	end

endmodule

FILE: rtl/spo_modp.sv
// ----------------------------------------------------------------------------
// spo_modp: ring step reduction pipeline
// Reduces the 16-bit ring step modulo the rank count, four remainder steps per
// stage over four stages, carrying the sub-group index alongside.
// ----------------------------------------------------------------------------
module spo_modp import spo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CNT_W-1:0]   n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [STEP_W-1:0]  ring_step,
	input  logic [GRP_W-1:0]   sub_group,
	output logic               out_valid,
	input  logic               out_ready,
	output mod_out_t           out_data
);

	localparam int MOD_STEPS = 4;

	typedef struct packed {
		logic [RANK_W-1:0] rem;
		logic [STEP_W-1:0] step;
		logic [GRP_W-1:0]  grp;
	} mod_stage_t;

	// Shift a few step bits into the remainder, reducing after each
	function automatic logic [RANK_W-1:0] mod_steps(
		input logic [RANK_W-1:0]    rem_in,
		input logic [MOD_STEPS-1:0] bits,
		input logic [CNT_W-1:0]     div
	);
		logic [CNT_W-1:0]  t;
		logic [RANK_W-1:0] rem;
		rem = rem_in;
		for (int i = MOD_STEPS - 1; i >= 0; i--) begin
			t = {rem, bits[i]};
			if (t >= div) begin
				t = t - div;
			end
			rem = t[RANK_W-1:0];
		end
		return rem;
	endfunction

	mod_stage_t d_s1, d_s2, d_s3, d_s4;
	mod_stage_t nx_s1, nx_s2, nx_s3, nx_s4;
	logic       v_s1, v_s2, v_s3, v_s4;
	logic       en_s1, en_s2, en_s3, en_s4;

	// Per-stage advance: a stage moves when empty or when the next one moves
	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		nx_s1.rem  = mod_steps('0, ring_step[STEP_W-1 -: MOD_STEPS], n);
		nx_s1.step = ring_step;
		nx_s1.grp  = sub_group;
		nx_s2      = d_s1;
		nx_s2.rem  = mod_steps(d_s1.rem, d_s1.step[STEP_W-1-MOD_STEPS -: MOD_STEPS], n);
		nx_s3      = d_s2;
		nx_s3.rem  = mod_steps(d_s2.rem, d_s2.step[STEP_W-1-2*MOD_STEPS -: MOD_STEPS], n);
		nx_s4      = d_s3;
		nx_s4.rem  = mod_steps(d_s3.rem, d_s3.step[STEP_W-1-3*MOD_STEPS -: MOD_STEPS], n);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (en_s1) d_s1 <= nx_s1;
		if (en_s2) d_s2 <= nx_s2;
		if (en_s3) d_s3 <= nx_s3;
		if (en_s4) d_s4 <= nx_s4;
	end

	assign out_valid         = v_s4;
	assign out_data.step_mod = d_s4.rem;
	assign out_data.grp      = d_s4.grp;

endmodule

FILE: rtl/spo_offs.sv
// ----------------------------------------------------------------------------
// spo_offs: source rank and offset pipeline
// Finds the source rank, forms the query and key chunk indexes for the mode,
// and scales them by the chunk length (by one in striped mode) into the output register.
// ----------------------------------------------------------------------------
module spo_offs import spo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  mod_out_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OFF_W-1:0]   query_offset,
	output logic [RANK_W-1:0]  holder_rank,
	output logic [OFF_W-1:0]   key_offset,
	output logic [SEQ_W-1:0]   chunk_length,
	output logic [CNT_W-1:0]   position_step,
	output logic [SPLIT_W-1:0] group_total,
	output logic               group_error
);

	localparam int BASE_W = SPLIT_W + CNT_W;

	logic en_s5, en_s6, en_s7;
	logic v_s5, v_s6, v_s7;

	logic                zig;
	logic                striped;

	logic [CNT_W:0]      src_sum;
	logic [RANK_W-1:0]   src_s5;
	logic [GRP_W-1:0]    grp_s5;

	logic                err;
	logic [GRP_W-2:0]    half;
	logic [SPLIT_W-1:0]  fac;
	logic [BASE_W-1:0]   base;
	logic [CNT_W-1:0]    mir_q;
	logic [CNT_W-1:0]    mir_k;
	logic [BASE_W-1:0]   zidx_q;
	logic [BASE_W-1:0]   zidx_k;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_k;
	logic [SEQ_W-1:0]    coef;
	logic [IDX_W-1:0]    idx_q_s6;
	logic [IDX_W-1:0]    idx_k_s6;
	logic [SEQ_W-1:0]    coef_s6;
	logic                err_s6;
	logic [RANK_W-1:0]   src_s6;

	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   prod_k;
	logic [OFF_W-1:0]    q_s7;
	logic [OFF_W-1:0]    k_s7;
	logic [RANK_W-1:0]   src_s7;
	logic                err_s7;

	assign zig     = cfg.mode == MODE_ZIGZAG;
	assign striped = cfg.mode == MODE_STRIPED;

	// Stage advance
	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	// Source rank: own minus step, wrapped into the ring
	always_comb begin
		if (in_data.step_mod <= cfg.r) begin
			src_sum = (CNT_W+1)'(cfg.r) - (CNT_W+1)'(in_data.step_mod);
		end else begin
			src_sum = (CNT_W+1)'(cfg.r) + (CNT_W+1)'(cfg.n) - (CNT_W+1)'(in_data.step_mod);
		end
	end

	// Chunk indexes: in zigzag mode even groups count outward, odd groups mirror inward
	always_comb begin
		err    = zig && (SPLIT_W'(grp_s5) >= cfg.s);
		half   = grp_s5[GRP_W-1:1];
		fac    = grp_s5[0] ? (cfg.s - SPLIT_W'(1) - SPLIT_W'(half)) : SPLIT_W'(half);
		base   = BASE_W'(fac) * BASE_W'(cfg.n);
		mir_q  = cfg.n - CNT_W'(1) - CNT_W'(cfg.r);
		mir_k  = cfg.n - CNT_W'(1) - CNT_W'(src_s5);
		zidx_q = base + (grp_s5[0] ? BASE_W'(mir_q) : BASE_W'(cfg.r));
		zidx_k = base + (grp_s5[0] ? BASE_W'(mir_k) : BASE_W'(src_s5));
		if (zig) begin
			idx_q = zidx_q[IDX_W-1:0];
			idx_k = zidx_k[IDX_W-1:0];
			coef  = cfg.len_z;
		end else begin
			idx_q = IDX_W'(cfg.r);
			idx_k = IDX_W'(src_s5);
			coef  = striped ? SEQ_W'(1) : cfg.len_c;
		end
	end

	// Scale indexes by chunk length, keeping the field width
	assign prod_q = PROD_W'(idx_q_s6) * PROD_W'(coef_s6);
	assign prod_k = PROD_W'(idx_k_s6) * PROD_W'(coef_s6);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (en_s5) begin
			src_s5 <= src_sum[RANK_W-1:0];
			grp_s5 <= in_data.grp;
		end
		if (en_s6) begin
			idx_q_s6 <= idx_q;
			idx_k_s6 <= idx_k;
			coef_s6  <= coef;
			err_s6   <= err;
			src_s6   <= src_s5;
		end
		if (en_s7) begin
			q_s7   <= err_s6 ? '0 : prod_q[OFF_W-1:0];
			k_s7   <= err_s6 ? '0 : prod_k[OFF_W-1:0];
			src_s7 <= src_s6;
			err_s7 <= err_s6;
		end
	end

	assign out_valid     = v_s7;
	assign query_offset  = q_s7;
	assign key_offset    = k_s7;
	assign holder_rank   = src_s7;
	assign group_error   = err_s7;

	// Mode-wide fields follow the configuration; the user must hold it while items run (not enforced here)
	assign chunk_length  = zig ? cfg.len_z : cfg.len_c;
	assign position_step = striped ? cfg.n : CNT_W'(1);
	assign group_total   = zig ? cfg.s : SPLIT_W'(1);

endmodule

FILE: rtl/sequence_partition_offset_calc.sv
// ----------------------------------------------------------------------------
// sequence_partition_offset_calc: ring sequence partition offsets
// Per ring step and sub-group, gives query and key base offsets, source rank,
// chunk length, position stride, group count and a sub-group error flag.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                    Payload
// input     in_valid / in_ready          ring_step, sub_group
// output    out_valid / out_ready        query_offset, holder_rank, key_offset,
//                                        chunk_length, position_step,
//                                        group_total, group_error
// config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One transaction per cycle sustained while out_ready is high and no setup
// runs; a result passes through seven register stages: four of
// step-mod-N (four remainder steps each), one for the source rank, one for
// the chunk indexes, one for the multiply.
// After reset and after every register write the config sequencer runs a
// setup state and then three divisions, all with in_ready low;
// in_ready is also low in the access cycle of the write itself.
// Each stage advances when empty or when the next one advances, so a stall
// on out_ready fills bubbles first and drops or repeats nothing.
//
module sequence_partition_offset_calc import spo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [STEP_W-1:0]     ring_step,
	input  logic [GRP_W-1:0]      sub_group,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OFF_W-1:0]      query_offset,
	output logic [RANK_W-1:0]     holder_rank,
	output logic [OFF_W-1:0]      key_offset,
	output logic [SEQ_W-1:0]      chunk_length,
	output logic [CNT_W-1:0]      position_step,
	output logic [SPLIT_W-1:0]    group_total,
	output logic                  group_error
);

	cfg_t     cfg;
	logic     mod_in_valid;
	logic     mod_in_ready;
	logic     mod_out_valid;
	logic     offs_ready;
	mod_out_t mod_data;

	spo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Hold off new transactions while derived values are being recomputed
	assign in_ready     = mod_in_ready && !cfg.busy;
	assign mod_in_valid = in_valid && !cfg.busy;

	spo_modp u_modp (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (cfg.n),
		.in_valid  (mod_in_valid),
		.in_ready  (mod_in_ready),
		.ring_step (ring_step),
		.sub_group (sub_group),
		.out_valid (mod_out_valid),
		.out_ready (offs_ready),
		.out_data  (mod_data)
	);

	spo_offs u_offs (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (mod_out_valid),
		.in_ready      (offs_ready),
		.in_data       (mod_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.query_offset  (query_offset),
		.holder_rank   (holder_rank),
		.key_offset    (key_offset),
		.chunk_length  (chunk_length),
		.position_step (position_step),
		.group_total   (group_total),
		.group_error   (group_error)
	);

	// A bad sub-group zeroes both offsets
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && group_error |-> (query_offset == '0) && (key_offset == '0))
		else $error("offsets not cleared on sub-group error");

	// The source rank stays inside the ring
	a_src_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CNT_W'(holder_rank) < cfg.n))
		else $error("source rank outside the ring");

	// Sub-group errors only arise in zigzag mode
	a_err_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && group_error |-> (cfg.mode == MODE_ZIGZAG))
		else $error("sub-group error outside zigzag mode");

endmodule
